// ===== rtl/pfe_pkg.sv =====
// Package for the postfix expression evaluator: sizes, ASCII codes, status codes,
// sequencer states and the shared-unit operation type. No dependencies.
package pfe_pkg;
	localparam int StackDepth = 64;
	localparam int PtrW = $clog2(StackDepth);
	localparam int CntW = $clog2(StackDepth + 1);

	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChMul   = 8'h2A;
	localparam logic [7:0] ChDiv   = 8'h2F;
	localparam logic [7:0] ChPow   = 8'h5E;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	localparam logic [2:0] StOk       = 3'd0;
	localparam logic [2:0] StFew      = 3'd1;
	localparam logic [2:0] StDivZero  = 3'd2;
	localparam logic [2:0] StBadChar  = 3'd3;
	localparam logic [2:0] StOverflow = 3'd4;
	localparam logic [2:0] StNotOne   = 3'd5;

	typedef enum logic [1:0] {OP_DIV, OP_POW} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic div_zero;
	} alu_stat_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD1, S_RD2, S_EXEC, S_WAIT, S_WB, S_OUT
	} state_t;
endpackage

// ===== rtl/pfe_alu.sv =====
// Shared multi-cycle unit for division (restoring, one bit a cycle) and
// power (square-and-multiply, one exponent bit a cycle). Uses pfe_pkg.
module pfe_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pfe_pkg::alu_cmd_t    cmd,
	input  logic [31:0]          lhs,
	input  logic [31:0]          rhs,
	output pfe_pkg::alu_stat_t   stat,
	output logic [31:0]          res
);
	logic        busy_q, done_q, dz_q, neg_q;
	pfe_pkg::op_t op_q;
	logic [4:0]  cnt_q;
	logic [31:0] a_q, b_q, r_q, acc_q;
	logic [32:0] rem_q;
	logic [32:0] trial;
	logic [32:0] rem_sh;
	logic [31:0] lmag, rmag;

	assign lmag = lhs[31] ? 32'(0 - lhs) : lhs;
	assign rmag = rhs[31] ? 32'(0 - rhs) : rhs;
	assign rem_sh = {rem_q[31:0], a_q[31]};
	assign trial = rem_sh - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !cmd.start && cnt_q == 5'd31;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= cmd.op;
			cnt_q <= 5'd0;
			rem_q <= 33'd0;
			acc_q <= 32'd1;
			if (cmd.op == pfe_pkg::OP_DIV) begin
				a_q   <= lmag;
				b_q   <= rmag;
				neg_q <= lhs[31] ^ rhs[31];
				dz_q  <= (rhs == 32'd0);
			end else begin
				a_q <= lhs;
				b_q <= rhs;
				dz_q <= rhs[31] && (lhs == 32'd0);
				if (rhs[31]) begin
					if (lhs == 32'd1) r_q <= 32'd1;
					else if (lhs == 32'hFFFFFFFF) r_q <= rhs[0] ? 32'hFFFFFFFF : 32'd1;
					else r_q <= 32'd0;
				end
			end
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (op_q == pfe_pkg::OP_DIV) begin
				a_q <= {a_q[30:0], ~trial[32]};
				rem_q <= trial[32] ? rem_sh : trial;
				if (cnt_q == 5'd31) begin
					// last quotient bit joins a_q's shift this cycle
					r_q <= neg_q ? 32'(0 - {a_q[30:0], ~trial[32]})
						: {a_q[30:0], ~trial[32]};
				end
			end else if (!b_q[31]) begin
				// a_q: running square; b_q shifts exponent bits down
				if (b_q[0]) acc_q <= 32'(acc_q * a_q);
				a_q <= 32'(a_q * a_q);
				b_q <= {1'b0, b_q[31:1]};
				if (cnt_q == 5'd31) r_q <= acc_q;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.div_zero = dz_q;
	assign res = r_q;
endmodule

// ===== rtl/postfix_expression_evaluator_core.sv =====
// Top level of the postfix expression evaluator: stack memory, sequencer,
// output register. Depends on pfe_pkg and pfe_alu.
//
// Usage: send one ASCII character per beat on s_axis (tdata = symbol,
// tlast = final character of the expression). Digits push 0-9; + - * / ^
// pop two operands and push the 32-bit wrapping result. On the tlast beat
// one result beat leaves on m_axis: tdata = value, tuser = status.
// Sequencing: a digit or bad character is taken in its accept beat; + - *
// pass through S_RD1, S_RD2 and S_EXEC (two stack memory reads, one register
// each); / and ^ add S_WAIT and S_WB for the 32 one-bit-per-cycle iterations
// of the shared unit. A tlast beat passes S_OUT to load the output register.
// The block takes one character at a time; s_axis_tready is low while
// it works and while a result waits on a stalled m_axis receiver.
// Reset clears stack count, error latch and output valid; stack
// contents are undefined until written and never read before that.
module postfix_expression_evaluator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // last_symbol
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] value
	output logic [2:0]  m_axis_tuser    // [2:0] status
);
	localparam int PW = pfe_pkg::PtrW;
	localparam int CW = pfe_pkg::CntW;

	pfe_pkg::state_t state_q, state_d;
	logic [31:0] mem [pfe_pkg::StackDepth];
	logic [31:0] rd_q, lhs_q, rhs_q;
	logic [CW-1:0] cnt_q;
	logic [2:0] err_q;
	logic [7:0] sym_q;
	logic last_q;
	logic ovalid_q;
	logic [31:0] oval_q;
	logic [2:0] ost_q;
	logic [PW-1:0] rd_addr;
	logic wr_en;
	logic [PW-1:0] wr_addr;
	logic [31:0] wr_data;
	logic [31:0] res_fast, alu_res;
	pfe_pkg::alu_cmd_t cmd;
	pfe_pkg::alu_stat_t ast;
	logic is_digit, is_op, is_slow;

	assign is_digit = s_axis_tdata >= pfe_pkg::ChZero && s_axis_tdata <= pfe_pkg::ChNine;
	assign is_op = s_axis_tdata == pfe_pkg::ChPlus || s_axis_tdata == pfe_pkg::ChMinus
		|| s_axis_tdata == pfe_pkg::ChMul || s_axis_tdata == pfe_pkg::ChDiv
		|| s_axis_tdata == pfe_pkg::ChPow;
	assign is_slow = sym_q == pfe_pkg::ChDiv || sym_q == pfe_pkg::ChPow;
	assign s_axis_tready = (state_q == pfe_pkg::S_IDLE) && !ovalid_q;

	pfe_alu u_alu (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .lhs(lhs_q), .rhs(rhs_q),
		.stat(ast), .res(alu_res)
	);

	always_comb begin
		unique case (sym_q)
			pfe_pkg::ChPlus:  res_fast = lhs_q + rhs_q;
			pfe_pkg::ChMinus: res_fast = lhs_q - rhs_q;
			default:          res_fast = 32'(lhs_q * rhs_q);
		endcase
	end

	always_comb begin
		state_d = state_q;
		cmd.start = 1'b0;
		cmd.op = (sym_q == pfe_pkg::ChDiv) ? pfe_pkg::OP_DIV : pfe_pkg::OP_POW;
		rd_addr = PW'(cnt_q - CW'(1));
		wr_en = 1'b0;
		wr_addr = PW'(cnt_q - CW'(2));
		wr_data = res_fast;
		unique case (state_q)
			pfe_pkg::S_IDLE: begin
				if (s_axis_tvalid && s_axis_tready) begin
					if (err_q == pfe_pkg::StOk && is_digit
						&& cnt_q != CW'(pfe_pkg::StackDepth)) begin
						wr_en = 1'b1;
						wr_addr = PW'(cnt_q);
						wr_data = {28'd0, 4'(s_axis_tdata - pfe_pkg::ChZero)};
					end
					if (err_q == pfe_pkg::StOk && is_op && cnt_q >= CW'(2))
						state_d = pfe_pkg::S_RD1;
					else if (s_axis_tlast)
						state_d = pfe_pkg::S_OUT;
				end
			end
			pfe_pkg::S_RD1: begin
				rd_addr = PW'(cnt_q - CW'(2));
				state_d = pfe_pkg::S_RD2;
			end
			pfe_pkg::S_RD2: state_d = pfe_pkg::S_EXEC;
			pfe_pkg::S_EXEC: begin
				if (is_slow) begin
					cmd.start = 1'b1;
					state_d = pfe_pkg::S_WAIT;
				end else begin
					wr_en = 1'b1;
					state_d = last_q ? pfe_pkg::S_OUT : pfe_pkg::S_IDLE;
				end
			end
			pfe_pkg::S_WAIT: if (ast.done) state_d = pfe_pkg::S_WB;
			pfe_pkg::S_WB: begin
				wr_en = !ast.div_zero;
				wr_data = alu_res;
				state_d = last_q ? pfe_pkg::S_OUT : pfe_pkg::S_IDLE;
			end
			pfe_pkg::S_OUT: begin
				rd_addr = PW'(0);
				state_d = pfe_pkg::S_IDLE;
			end
			default: state_d = pfe_pkg::S_IDLE;
		endcase
	end

	// top is read in the accept beat, lhs in S_RD1; both are in place for S_EXEC
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
		if (state_q == pfe_pkg::S_IDLE) begin
			sym_q <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
		if (state_q == pfe_pkg::S_RD1) rhs_q <= rd_q;
		if (state_q == pfe_pkg::S_RD2) lhs_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::S_IDLE;
			cnt_q <= '0;
			err_q <= pfe_pkg::StOk;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
			if (state_q == pfe_pkg::S_IDLE && s_axis_tvalid && s_axis_tready
				&& err_q == pfe_pkg::StOk) begin
				if (is_digit) begin
					if (cnt_q == CW'(pfe_pkg::StackDepth)) err_q <= pfe_pkg::StOverflow;
					else cnt_q <= cnt_q + CW'(1);
				end else if (!is_op) err_q <= pfe_pkg::StBadChar;
				else if (cnt_q < CW'(2)) err_q <= pfe_pkg::StFew;
			end
			if (state_q == pfe_pkg::S_EXEC && !is_slow) cnt_q <= cnt_q - CW'(1);
			if (state_q == pfe_pkg::S_WB) begin
				if (ast.div_zero) err_q <= pfe_pkg::StDivZero;
				else cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == pfe_pkg::S_OUT) begin
				ovalid_q <= 1'b1;
				cnt_q <= '0;
				err_q <= pfe_pkg::StOk;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pfe_pkg::S_OUT) begin
			if (err_q != pfe_pkg::StOk) begin
				ost_q <= err_q;
				oval_q <= 32'd0;
			end else if (cnt_q != CW'(1)) begin
				ost_q <= pfe_pkg::StNotOne;
				oval_q <= 32'd0;
			end else begin
				ost_q <= pfe_pkg::StOk;
				oval_q <= mem[0];
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = oval_q;
	assign m_axis_tuser = ost_q;
endmodule
